// File: rtl/pvma_pkg.sv
// shared types, register codes and helpers for the planar video memory access block
package pvma_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned REM_W   = ADDR_W + 4;
  localparam int unsigned PLANES  = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // register indexes on the config port
  localparam logic [2:0] REG_SET_RESET_VALUE   = 3'd0;
  localparam logic [2:0] REG_SET_RESET_ENABLE  = 3'd1;
  localparam logic [2:0] REG_COMPARE_COLOUR    = 3'd2;
  localparam logic [2:0] REG_COMPARE_DONT_CARE = 3'd3;
  localparam logic [2:0] REG_ROTATE_FUNCTION   = 3'd4;
  localparam logic [2:0] REG_MODE_SELECT       = 3'd5;
  localparam logic [2:0] REG_BIT_MASK          = 3'd6;
  localparam logic [2:0] REG_PLANE_WRITE_MASK  = 3'd7;

  // write modes, mode_select[1:0]
  typedef enum logic [1:0] {
    WM_CPU_DATA  = 2'd0,
    WM_LATCH     = 2'd1,
    WM_FILL      = 2'd2,
    WM_SET_RESET = 2'd3
  } wmode_e;

  // logic function, rotate_function[4:3]
  typedef enum logic [1:0] {
    LOP_REPLACE = 2'd0,
    LOP_AND     = 2'd1,
    LOP_OR      = 2'd2,
    LOP_XOR     = 2'd3
  } lop_e;

  // raw graphics controller registers
  typedef struct packed {
    logic [3:0] set_reset_value;
    logic [3:0] set_reset_enable;
    logic [3:0] compare_colour;
    logic [3:0] compare_dont_care;
    logic [4:0] rotate_function;
    logic [5:0] mode_select;
    logic [7:0] bit_mask;
    logic [3:0] plane_write_mask;
  } cfg_t;

  // rotate a byte right
  function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] dbl;
    dbl = {v, v} >> n;
    return dbl[7:0];
  endfunction

endpackage

// File: rtl/pvma_plane_ram.sv
// four-plane video memory with per-plane write enables and registered read data
module pvma_plane_ram #(
  parameter int unsigned WORDS = 65536
) (
  input  logic                                         clk_i,
  input  logic                                         re_i,
  input  logic                                         we_i,
  input  logic [pvma_pkg::PLANES-1:0]                  be_i,
  input  logic [$clog2(WORDS)-1:0]                     addr_i,
  input  logic [pvma_pkg::WORD_W-1:0]                  wdata_i,
  output logic [pvma_pkg::WORD_W-1:0]                  rdata_o
);
  import pvma_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;

  // byte-lane writes, one lane per plane
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < PLANES; p++) begin
      if (we_i && be_i[p]) begin
        mem[addr_i][8*p +: 8] <= wdata_i[8*p +: 8];
      end
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pvma_cfg_regs.sv
// graphics controller register file behind the apb-style config port
module pvma_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvma_pkg::PADDR_W-1:0]  paddr,
  input  logic [pvma_pkg::PDATA_W-1:0]  pwdata,
  output logic [pvma_pkg::PDATA_W-1:0]  prdata,
  output pvma_pkg::cfg_t                cfg_o
);
  import pvma_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SET_RESET_VALUE:   cfg_q.set_reset_value   <= pwdata[3:0];
        REG_SET_RESET_ENABLE:  cfg_q.set_reset_enable  <= pwdata[3:0];
        REG_COMPARE_COLOUR:    cfg_q.compare_colour    <= pwdata[3:0];
        REG_COMPARE_DONT_CARE: cfg_q.compare_dont_care <= pwdata[3:0];
        REG_ROTATE_FUNCTION:   cfg_q.rotate_function   <= pwdata[4:0];
        REG_MODE_SELECT:       cfg_q.mode_select       <= pwdata[5:0];
        REG_BIT_MASK:          cfg_q.bit_mask          <= pwdata[7:0];
        REG_PLANE_WRITE_MASK:  cfg_q.plane_write_mask  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SET_RESET_VALUE:   prdata = {28'd0, cfg_q.set_reset_value};
      REG_SET_RESET_ENABLE:  prdata = {28'd0, cfg_q.set_reset_enable};
      REG_COMPARE_COLOUR:    prdata = {28'd0, cfg_q.compare_colour};
      REG_COMPARE_DONT_CARE: prdata = {28'd0, cfg_q.compare_dont_care};
      REG_ROTATE_FUNCTION:   prdata = {27'd0, cfg_q.rotate_function};
      REG_MODE_SELECT:       prdata = {26'd0, cfg_q.mode_select};
      REG_BIT_MASK:          prdata = {24'd0, cfg_q.bit_mask};
      REG_PLANE_WRITE_MASK:  prdata = {28'd0, cfg_q.plane_write_mask};
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pvma_write_unit.sv
// per-plane write data: write mode, set/reset, rotate, logic function and bit mask
module pvma_write_unit (
  input  pvma_pkg::cfg_t                 cfg_i,
  input  logic [pvma_pkg::WORD_W-1:0]    latch_i,
  input  logic [7:0]                     cpu_i,
  output logic [pvma_pkg::WORD_W-1:0]    wdata_o
);
  import pvma_pkg::*;

  wmode_e     wmode;
  lop_e       lop;
  logic [7:0] rot;

  assign wmode = wmode_e'(cfg_i.mode_select[1:0]);
  assign lop   = lop_e'(cfg_i.rotate_function[4:3]);
  assign rot   = ror8(cpu_i, cfg_i.rotate_function[2:0]);

  // one plane byte per lane
  always_comb begin
    logic [7:0] lat;
    logic [7:0] v;
    logic [7:0] msk;
    logic [7:0] r;
    for (int p = 0; p < PLANES; p++) begin
      lat = latch_i[8*p +: 8];
      msk = cfg_i.bit_mask;
      // value entering the logic step
      case (wmode)
        WM_CPU_DATA: begin
          v = cfg_i.set_reset_enable[p] ? {8{cfg_i.set_reset_value[p]}} : rot;
        end
        WM_FILL: begin
          v = {8{cpu_i[p]}};
        end
        WM_SET_RESET: begin
          v   = {8{cfg_i.set_reset_value[p]}};
          msk = rot & cfg_i.bit_mask;
        end
        default: begin
          v = lat;
        end
      endcase
      // logic function against the latch
      case (lop)
        LOP_AND: r = v & lat;
        LOP_OR:  r = v | lat;
        LOP_XOR: r = v ^ lat;
        default: r = v;
      endcase
      if (wmode == WM_LATCH) begin
        wdata_o[8*p +: 8] = lat;
      end else begin
        wdata_o[8*p +: 8] = (r & msk) | (lat & ~msk);
      end
    end
  end

endmodule

// File: rtl/planar_video_memory_access.sv
// top level of the planar video memory access path
// Planar graphics-controller access path between a CPU and a four-plane video memory of
// PLANE_WORDS 32-bit words (4096 to 65536; addresses wrap modulo PLANE_WORDS). Accesses are
// taken one per cycle. A write goes straight into the plane memory with per-plane byte
// enables in the cycle it is accepted. A read issues a synchronous memory read; the next
// cycle loads the plane latches and, once the output register is free, places read_byte
// in it, so a read result comes from the output register. A write that follows a read
// directly sees the freshly loaded latches through a bypass. The input stalls only while
// a read's data waits for a full output register. The plane memory is not cleared at reset.
// Configuration registers sit at byte addresses 4*i on the APB-style port.
module planar_video_memory_access #(
  parameter int unsigned PLANE_WORDS = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvma_pkg::PADDR_W-1:0]  paddr,
  input  logic [pvma_pkg::PDATA_W-1:0]  pwdata,
  output logic [pvma_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // access channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [pvma_pkg::ADDR_W-1:0]   word_address_i,
  input  logic [7:0]                    write_byte_i,
  // read result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    read_byte_o
);
  import pvma_pkg::*;

  localparam int unsigned AddrW = $clog2(PLANE_WORDS);
  localparam logic [REM_W-1:0] WordsExt = REM_W'(PLANE_WORDS);

  cfg_t              cfg;
  logic              accept;
  logic              slot_free;
  logic [REM_W-1:0]  rem;
  logic [AddrW-1:0]  mem_addr;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] latch_eff;
  logic [WORD_W-1:0] latch_q;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic [7:0]        rd_byte;

  assign pready = 1'b1;

  pvma_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // handshake: a pending read may only retire into a free output register
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = !rd_pend_q || slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // address modulo the memory depth, quotient below 16
  always_comb begin
    rem = {4'd0, word_address_i};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (WordsExt << k)) begin
        rem = rem - (WordsExt << k);
      end
    end
  end
  assign mem_addr = rem[AddrW-1:0];

  // latches bypass the memory read data while a read is pending
  assign latch_eff = rd_pend_q ? ram_rdata : latch_q;

  pvma_write_unit u_wr (
    .cfg_i   (cfg),
    .latch_i (latch_eff),
    .cpu_i   (write_byte_i),
    .wdata_o (wdata)
  );

  pvma_plane_ram #(
    .WORDS (PLANE_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (accept && !kind_i),
    .we_i    (accept && kind_i),
    .be_i    (cfg.plane_write_mask),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (ram_rdata)
  );

  // read result: plane select or colour compare
  always_comb begin
    if (cfg.mode_select[3]) begin
      rd_byte = 8'hff;
      for (int p = 0; p < PLANES; p++) begin
        if (cfg.compare_dont_care[p]) begin
          rd_byte = rd_byte & ~(latch_eff[8*p +: 8] ^ {8{cfg.compare_colour[p]}});
        end
      end
    end else begin
      case (cfg.mode_select[5:4])
        2'd1:    rd_byte = latch_eff[15:8];
        2'd2:    rd_byte = latch_eff[23:16];
        2'd3:    rd_byte = latch_eff[31:24];
        default: rd_byte = latch_eff[7:0];
      endcase
    end
  end

  // pending read tracking
  assign rd_pend_d = (accept && !kind_i) || (rd_pend_q && !slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      latch_q   <= '0;
    end else begin
      rd_pend_q <= rd_pend_d;
      if (rd_pend_q) begin
        latch_q <= ram_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_pend_q && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q && slot_free) begin
      out_byte_q <= rd_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = out_byte_q;

endmodule

// File: verif/tb_planar_video_memory_access.sv
`timescale 1ns / 1ps
// self-checking testbench for the planar video memory access block
module tb_planar_video_memory_access;
  import pvma_pkg::*;

  localparam int unsigned PLANE_WORDS    = 65536;
  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 20;
  localparam bit          KIND_READ      = 1'b0;
  localparam bit          KIND_WRITE     = 1'b1;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic               kind_i         = 1'b0;
  logic [ADDR_W-1:0]  word_address_i = '0;
  logic [7:0]         write_byte_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [7:0]         read_byte_o;

  // predictor state
  cfg_t        model_cfg;
  logic [31:0] model_latches;
  logic [31:0] plane_mem [int unsigned];
  logic [3:0]  plane_filled [int unsigned];
  int unsigned full_words [$];
  logic [7:0]  pending_read_bytes [$];

  // run control and bookkeeping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_ask      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_reads       = 0;
  int unsigned n_writes      = 0;
  int unsigned n_beats       = 0;
  int unsigned n_reg_writes  = 0;
  int unsigned n_errors      = 0;

  planar_video_memory_access #(
    .PLANE_WORDS(PLANE_WORDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .word_address_i(word_address_i),
    .write_byte_i  (write_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_byte_o   (read_byte_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // register field encodings
  function automatic logic [31:0] mode_word(logic [1:0] plane, bit compare, wmode_e wm);
    return {26'd0, plane, compare, 1'b0, wm};
  endfunction

  function automatic logic [31:0] rotate_word(lop_e lop, logic [2:0] count);
    return {27'd0, lop, count};
  endfunction

  // byte rotation, one position per step
  function automatic logic [7:0] byte_ror(logic [7:0] v, logic [2:0] n);
    logic [7:0] r;
    r = v;
    for (int i = 0; i < n; i++) r = {r[0], r[7:1]};
    return r;
  endfunction

  // byte that a write stores into plane p
  function automatic logic [7:0] written_plane_byte(int p, logic [7:0] cpu);
    logic [7:0] lat, rot, v, msk, r;
    lat = model_latches[8*p +: 8];
    rot = byte_ror(cpu, model_cfg.rotate_function[2:0]);
    msk = model_cfg.bit_mask;
    v   = rot;
    case (wmode_e'(model_cfg.mode_select[1:0]))
      WM_CPU_DATA: if (model_cfg.set_reset_enable[p]) v = {8{model_cfg.set_reset_value[p]}};
      WM_LATCH: msk = '0;
      WM_FILL: v = {8{cpu[p]}};
      default: begin
        v   = {8{model_cfg.set_reset_value[p]}};
        msk = rot & model_cfg.bit_mask;
      end
    endcase
    case (lop_e'(model_cfg.rotate_function[4:3]))
      LOP_AND: r = v & lat;
      LOP_OR:  r = v | lat;
      LOP_XOR: r = v ^ lat;
      default: r = v;
    endcase
    return (r & msk) | (lat & ~msk);
  endfunction

  // pixel bits whose used planes all match the compare colour
  function automatic logic [7:0] colour_match_byte();
    logic [7:0] res;
    res = 8'hff;
    for (int p = 0; p < PLANES; p++)
      if (model_cfg.compare_dont_care[p])
        res &= ~(model_latches[8*p +: 8] ^ {8{model_cfg.compare_colour[p]}});
    return res;
  endfunction

  // apply one accepted access to the predictor
  task automatic predict_access(bit is_write, logic [ADDR_W-1:0] addr, logic [7:0] cpu);
    int unsigned a;
    logic [31:0] word;
    logic [3:0]  planes;
    a    = addr % PLANE_WORDS;
    word = plane_mem.exists(a) ? plane_mem[a] : '0;
    if (!is_write) begin
      model_latches = word;
      if (model_cfg.mode_select[3]) pending_read_bytes.push_back(colour_match_byte());
      else pending_read_bytes.push_back(model_latches[8*model_cfg.mode_select[5:4] +: 8]);
      n_reads++;
    end else begin
      for (int p = 0; p < PLANES; p++)
        if (model_cfg.plane_write_mask[p]) word[8*p +: 8] = written_plane_byte(p, cpu);
      plane_mem[a] = word;
      planes = plane_filled.exists(a) ? plane_filled[a] : 4'h0;
      // a word becomes readable once every plane has been stored
      if (planes != 4'hf && (planes | model_cfg.plane_write_mask) == 4'hf)
        full_words.push_back(a);
      plane_filled[a] = planes | model_cfg.plane_write_mask;
      n_writes++;
    end
  endtask

  // offer one access beat and wait for it to be taken
  task automatic send_access(bit is_write, logic [ADDR_W-1:0] addr, logic [7:0] cpu);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= is_write ? KIND_WRITE : KIND_READ;
    word_address_i <= addr;
    write_byte_i   <= cpu;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_access(is_write, addr, cpu);
  endtask

  // stop sending until every read beat is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_read_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write over the config port, only while idle
  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_SET_RESET_VALUE:   model_cfg.set_reset_value   = val[3:0];
      REG_SET_RESET_ENABLE:  model_cfg.set_reset_enable  = val[3:0];
      REG_COMPARE_COLOUR:    model_cfg.compare_colour    = val[3:0];
      REG_COMPARE_DONT_CARE: model_cfg.compare_dont_care = val[3:0];
      REG_ROTATE_FUNCTION:   model_cfg.rotate_function   = val[4:0];
      REG_MODE_SELECT:       model_cfg.mode_select       = val[5:0];
      REG_BIT_MASK:          model_cfg.bit_mask          = val[7:0];
      default:               model_cfg.plane_write_mask  = val[3:0];
    endcase
    n_reg_writes++;
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %02h, want %02h", $time, what, got, want);
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each read beat with the oldest predicted byte
  always @(posedge clk_i) begin : check_beat
    logic [7:0] want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      n_beats++;
      if (pending_read_bytes.size() == 0) begin
        report_mismatch("unexpected read beat", read_byte_o, 8'h00);
      end else begin
        want = pending_read_bytes.pop_front();
        if (read_byte_o !== want) report_mismatch("read_byte", read_byte_o, want);
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // every write mode, logic function, read mode and register extreme
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reg(REG_PLANE_WRITE_MASK, 32'hf);
    set_reg(REG_BIT_MASK, 32'hff);
    // plain cpu data writes at both ends of the address range
    send_access(KIND_WRITE, 16'h0000, 8'hff);
    send_access(KIND_WRITE, 16'hffff, 8'h5a);
    send_access(KIND_WRITE, 16'h1234, 8'h00);
    send_access(KIND_READ, 16'hffff, 8'hff);
    set_reg(REG_MODE_SELECT, mode_word(2'd3, 1'b0, WM_CPU_DATA));
    send_access(KIND_READ, 16'h0000, 8'h00);
    // set/reset drives planes 1 and 3 high, others low
    set_reg(REG_SET_RESET_VALUE, 32'ha);
    set_reg(REG_SET_RESET_ENABLE, 32'hf);
    set_reg(REG_MODE_SELECT, mode_word(2'd1, 1'b0, WM_CPU_DATA));
    send_access(KIND_WRITE, 16'h0001, 8'h3c);
    send_access(KIND_READ, 16'h0001, 8'h00);
    // colour compare with all planes used, then with none
    set_reg(REG_COMPARE_COLOUR, 32'ha);
    set_reg(REG_COMPARE_DONT_CARE, 32'hf);
    set_reg(REG_MODE_SELECT, mode_word(2'd0, 1'b1, WM_CPU_DATA));
    send_access(KIND_READ, 16'h0001, 8'hff);
    send_access(KIND_READ, 16'h1234, 8'h00);
    set_reg(REG_COMPARE_DONT_CARE, 32'h0);
    send_access(KIND_READ, 16'h1234, 8'hff);
    // latch copy to another word
    set_reg(REG_MODE_SELECT, mode_word(2'd0, 1'b0, WM_LATCH));
    send_access(KIND_READ, 16'hffff, 8'h00);
    send_access(KIND_WRITE, 16'h2000, 8'h00);
    send_access(KIND_READ, 16'h2000, 8'h00);
    // fill from cpu bits with xor and a half mask, right after a read
    set_reg(REG_ROTATE_FUNCTION, rotate_word(LOP_XOR, 3'd0));
    set_reg(REG_BIT_MASK, 32'h0f);
    set_reg(REG_MODE_SELECT, mode_word(2'd2, 1'b0, WM_FILL));
    send_access(KIND_READ, 16'h0001, 8'h00);
    send_access(KIND_WRITE, 16'h0001, 8'h05);
    send_access(KIND_READ, 16'h0001, 8'h00);
    // set/reset through a rotated cpu mask, with and then or
    set_reg(REG_ROTATE_FUNCTION, rotate_word(LOP_AND, 3'd7));
    set_reg(REG_BIT_MASK, 32'hff);
    set_reg(REG_MODE_SELECT, mode_word(2'd0, 1'b0, WM_SET_RESET));
    send_access(KIND_READ, 16'hffff, 8'h00);
    send_access(KIND_WRITE, 16'h0000, 8'h81);
    set_reg(REG_ROTATE_FUNCTION, rotate_word(LOP_OR, 3'd7));
    send_access(KIND_WRITE, 16'h1234, 8'h01);
    // every field at its top value, then an empty write mask
    set_reg(REG_SET_RESET_VALUE, 32'hf);
    set_reg(REG_COMPARE_COLOUR, 32'hf);
    set_reg(REG_COMPARE_DONT_CARE, 32'hf);
    set_reg(REG_ROTATE_FUNCTION, 32'h1f);
    set_reg(REG_MODE_SELECT, 32'h3f);
    set_reg(REG_BIT_MASK, 32'h00);
    set_reg(REG_PLANE_WRITE_MASK, 32'h0);
    send_access(KIND_WRITE, 16'h0000, 8'hff);
    send_access(KIND_READ, 16'h0000, 8'h00);
  endtask

  // fully written words at both ends of memory for later reads
  task automatic test_fill_pool();
    set_reg(REG_PLANE_WRITE_MASK, 32'hf);
    set_reg(REG_SET_RESET_ENABLE, 32'h0);
    set_reg(REG_ROTATE_FUNCTION, rotate_word(LOP_REPLACE, 3'd0));
    set_reg(REG_MODE_SELECT, mode_word(2'd0, 1'b0, WM_CPU_DATA));
    set_reg(REG_BIT_MASK, 32'hff);
    for (int i = 0; i < 32; i++) begin
      send_access(KIND_WRITE, ADDR_W'(i), 8'($urandom()));
      send_access(KIND_WRITE, ADDR_W'(16'hffe0 | i), 8'($urandom()));
    end
  endtask

  // new setting for every register, now and then all zero or all ones
  task automatic reroll_registers();
    int unsigned profile;
    logic [31:0] v;
    profile = $urandom_range(7);
    for (int i = 0; i < 8; i++) begin
      case (profile)
        0:       v = '0;
        1:       v = '1;
        default: v = $urandom();
      endcase
      set_reg(3'(i), v);
    end
  endtask

  // read-modify-write pairs most often, plus lone reads and scattered writes
  task automatic random_access();
    int unsigned pick;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(99);
    a    = ADDR_W'(full_words[$urandom_range(full_words.size() - 1)]);
    if (pick < 40) begin
      send_access(KIND_READ, a, 8'($urandom()));
      send_access(KIND_WRITE, a, 8'($urandom()));
    end else if (pick < 65) begin
      send_access(KIND_READ, a, 8'($urandom()));
    end else begin
      if (pick < 90) begin
        a = ADDR_W'($urandom_range(31));
        if ($urandom_range(1)) a |= 16'hffe0;
      end else begin
        a = ADDR_W'($urandom());
      end
      send_access(KIND_WRITE, a, 8'($urandom()));
    end
  endtask

  task automatic test_random_traffic(int unsigned items, int unsigned s_idle,
                                     int unsigned r_idle);
    int unsigned start;
    start         = n_reads + n_writes;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (n_reads + n_writes - start < items) begin
      if ((n_reads + n_writes - start) % 60 < 2 && $urandom_range(1)) reroll_registers();
      if ($urandom_range(29) == 0) settle();
      random_access();
    end
  endtask

  // long receiver hold-off while reads keep coming, so the input stalls
  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ask      = 1'b1;
    repeat (40)
      send_access(KIND_READ, ADDR_W'(full_words[$urandom_range(full_words.size() - 1)]),
                  8'($urandom()));
    settle();
  endtask

  initial begin
    model_cfg     = '0;
    model_latches = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_pool();
    test_random_traffic(230, 35, 79);
    test_random_traffic(230, 79, 35);
    test_random_traffic(230, 0, 0);
    test_backpressure();
    settle();
    $display("run covered %0d accesses (%0d reads, %0d writes), %0d register writes",
             n_reads + n_writes, n_reads, n_writes, n_reg_writes);
    $display("read beats checked: %0d, mismatches: %0d", n_beats, n_errors);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
